// File: design/fsft_pkg.sv
// ----------------------------------------------------------------------------
// fsft_pkg
// Shared types and constants for the flow shop flow time evaluator.
// ----------------------------------------------------------------------------
package fsft_pkg;

  localparam int MAX_JOBS     = 64;
  localparam int MAX_MACHINES = 16;
  localparam int TIME_BITS    = 16;

  localparam int JOB_W   = $clog2(MAX_JOBS);
  localparam int MACH_W  = $clog2(MAX_MACHINES);
  localparam int ADDR_W  = JOB_W + MACH_W;
  localparam int DEPTH   = MAX_JOBS * MAX_MACHINES;
  localparam int COMP_W  = 32;
  localparam int TOTAL_W = 40;
  localparam int MCNT_W  = 5;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // One operation after the table lookup, as it waits for the back end.
  typedef struct packed {
    logic                 func;
    logic [MACH_W-1:0]    mach;
    logic                 first;
    logic                 final_op;
    logic [TIME_BITS-1:0] ptime;
  } op_t;

endpackage

// File: design/fsft_front.sv
// ----------------------------------------------------------------------------
// fsft_front
// Input side: accepts beats, writes or reads the processing-time table and
// hands each operation with its looked-up time to the queue.
// ----------------------------------------------------------------------------
module fsft_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [fsft_pkg::JOB_W-1:0]      in_job_id,
  input  logic [fsft_pkg::MACH_W-1:0]     in_machine_id,
  input  logic [15:0]                     in_proc_time,
  input  logic                            in_first_job,
  input  logic                            in_final_job,
  input  logic [fsft_pkg::Q_CNT_W-1:0]    q_count,
  output logic                            push,
  output fsft_pkg::op_t                   push_op
);
  import fsft_pkg::*;

  logic [TIME_BITS-1:0] mem [DEPTH];
  logic [TIME_BITS-1:0] rd_data_r;
  logic                 s1_valid_r;
  logic                 s1_func_r;
  logic [MACH_W-1:0]    s1_mach_r;
  logic                 s1_first_r;
  logic                 s1_final_r;
  logic [ADDR_W-1:0]    addr;
  logic                 accept;
  logic [Q_CNT_W:0]     credit_use;

  // Credits: the queue must have room for everything already in flight.
  assign credit_use = {1'b0, q_count} + {{Q_CNT_W{1'b0}}, s1_valid_r};
  assign in_stall   = credit_use >= (Q_CNT_W+1)'(Q_DEPTH);
  assign accept     = in_valid && !in_stall;
  assign addr       = {in_job_id, in_machine_id};

  always_ff @(posedge clk) begin
    if (accept && in_func == FUNC_LOAD) begin
      mem[addr] <= in_proc_time[TIME_BITS-1:0];
    end
    if (accept) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_func_r  <= in_func;
      s1_mach_r  <= in_machine_id;
      s1_first_r <= in_first_job;
      s1_final_r <= in_final_job;
    end
  end

  assign push             = s1_valid_r;
  assign push_op.func     = s1_func_r;
  assign push_op.mach     = s1_mach_r;
  assign push_op.first    = s1_first_r;
  assign push_op.final_op = s1_final_r;
  assign push_op.ptime    = rd_data_r;

endmodule

// File: design/fsft_queue.sv
// ----------------------------------------------------------------------------
// fsft_queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module fsft_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  fsft_pkg::op_t                push_op,
  input  logic                         pop,
  output logic                         head_valid,
  output fsft_pkg::op_t                head_op,
  output logic [fsft_pkg::Q_CNT_W-1:0] count
);
  import fsft_pkg::*;

  op_t                entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
    if (push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

  assign head_valid = count_r != '0;
  assign head_op    = entries_r[rd_ptr_r];
  assign count      = count_r;

endmodule

// File: design/fsft_back.sv
// ----------------------------------------------------------------------------
// fsft_back
// Execution side: computes completion times, keeps the previous job's row
// and the running total, and holds the result in an output register.
// ----------------------------------------------------------------------------
module fsft_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fsft_pkg::MCNT_W-1:0]         machine_count,
  input  logic                                head_valid,
  input  fsft_pkg::op_t                       head_op,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fsft_pkg::COMP_W-1:0]         out_completion_time,
  output logic [fsft_pkg::TOTAL_W-1:0]        out_flow_time_total,
  output logic                                out_sequence_done
);
  import fsft_pkg::*;

  logic [COMP_W-1:0]  prev_job_row_r [MAX_MACHINES];
  logic [COMP_W-1:0]  prev_machine_done_r;
  logic [TOTAL_W-1:0] running_total_r;
  logic [TOTAL_W-1:0] running_total_nxt;
  logic               out_valid_r;
  logic [COMP_W-1:0]  comp_r;
  logic [TOTAL_W-1:0] total_r;
  logic               done_r;

  logic               eval;
  logic [COMP_W-1:0]  from_mach;
  logic [COMP_W-1:0]  from_job;
  logic [COMP_W-1:0]  later;
  logic [COMP_W:0]    sum_c;
  logic [COMP_W-1:0]  comp;
  logic [MACH_W-1:0]  last_mach;
  logic               is_last;
  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W:0]   sum_t;

  assign pop  = head_valid && (!out_valid_r || !out_stall);
  assign eval = head_op.func == FUNC_EVAL;

  // Effective machine count is clamped to 1..MAX_MACHINES.
  always_comb begin
    if (machine_count == '0) begin
      last_mach = '0;
    end else if (machine_count > MCNT_W'(MAX_MACHINES)) begin
      last_mach = MACH_W'(MAX_MACHINES - 1);
    end else begin
      last_mach = MACH_W'(machine_count - 1'b1);
    end
  end

  always_comb begin
    from_mach = (head_op.mach == '0) ? '0 : prev_machine_done_r;
    from_job  = head_op.first ? '0 : prev_job_row_r[head_op.mach];
    later     = (from_mach > from_job) ? from_mach : from_job;
    sum_c     = {1'b0, later} + {{(COMP_W+1-TIME_BITS){1'b0}}, head_op.ptime};
    comp      = sum_c[COMP_W] ? '1 : sum_c[COMP_W-1:0];
    is_last   = head_op.mach == last_mach;
    base      = head_op.first ? '0 : running_total_r;
    sum_t     = {1'b0, base} + {{(TOTAL_W+1-COMP_W){1'b0}}, comp};
    if (is_last) begin
      running_total_nxt = sum_t[TOTAL_W] ? '1 : sum_t[TOTAL_W-1:0];
    end else begin
      running_total_nxt = base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_MACHINES; i++) begin
        prev_job_row_r[i] <= '0;
      end
      prev_machine_done_r <= '0;
      running_total_r     <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      if (pop && eval) begin
        prev_job_row_r[head_op.mach] <= comp;
        prev_machine_done_r          <= comp;
        running_total_r              <= running_total_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pop) begin
      comp_r  <= eval ? comp : '0;
      total_r <= eval ? running_total_nxt : running_total_r;
      done_r  <= eval && is_last && head_op.final_op;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_completion_time = comp_r;
  assign out_flow_time_total = total_r;
  assign out_sequence_done   = done_r;

endmodule

// File: design/flow_shop_flow_time_eval.sv
// ----------------------------------------------------------------------------
// flow_shop_flow_time_eval
// Permutation flow shop evaluator: processing-time table plus completion
// time and total flow time computation, one operation per beat.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while in_stall is low, loads and
// evaluations alike, and gives one result beat for each. The processing-time
// table is read into a register when a beat is accepted, the looked-up
// operation is then written into the four-entry queue, and the back end
// loads its output register from the queue's head. The back end's single
// max-add-accumulate step per cycle sets the rate of one operation per cycle
// while the output is not stalled. The queue's credit count stalls the input
// once four operations are held in the queue and the table read stage behind
// a stalled output.
module flow_shop_flow_time_eval (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fsft_pkg::MCNT_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [fsft_pkg::JOB_W-1:0]   in_job_id,
  input  logic [fsft_pkg::MACH_W-1:0]  in_machine_id,
  input  logic [15:0]                  in_proc_time,
  input  logic                         in_first_job,
  input  logic                         in_final_job,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fsft_pkg::COMP_W-1:0]  out_completion_time,
  output logic [fsft_pkg::TOTAL_W-1:0] out_flow_time_total,
  output logic                         out_sequence_done
);
  import fsft_pkg::*;

  logic [MCNT_W-1:0]  machine_count_r;
  logic               push;
  op_t                push_op;
  logic               pop;
  logic               head_valid;
  op_t                head_op;
  logic [Q_CNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machine_count_r <= MCNT_W'(MAX_MACHINES);
    end else if (cfg_we) begin
      machine_count_r <= cfg_wdata;
    end
  end

  fsft_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_job_id     (in_job_id),
    .in_machine_id (in_machine_id),
    .in_proc_time  (in_proc_time),
    .in_first_job  (in_first_job),
    .in_final_job  (in_final_job),
    .q_count       (q_count),
    .push          (push),
    .push_op       (push_op)
  );

  fsft_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .count      (q_count)
  );

  fsft_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .machine_count       (machine_count_r),
    .head_valid          (head_valid),
    .head_op             (head_op),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_completion_time (out_completion_time),
    .out_flow_time_total (out_flow_time_total),
    .out_sequence_done   (out_sequence_done)
  );

  // The credit scheme must never let the queue overflow.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_count < Q_CNT_W'(Q_DEPTH))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_count != '0)
    else $error("queue pop while empty");

  a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> push)
    else $error("accepted beat did not reach the queue");

endmodule

// File: tb/tb_flow_shop_flow_time_eval.sv
// ----------------------------------------------------------------------------
// tb_flow_shop_flow_time_eval
// Self-checking testbench for the flow shop flow time evaluator. Loads
// processing times, streams job sequences with random content under
// several machine counts, and predicts every result beat in step with
// the traffic. The sender idles in bursts and the receiver stalls on its
// own pattern, with one long output hold-off and mid-sequence pauses.
// ----------------------------------------------------------------------------
module tb_flow_shop_flow_time_eval;
  timeunit 1ns;
  timeprecision 1ps;

  import fsft_pkg::*;

  typedef struct {
    logic        func;
    logic [5:0]  job;
    logic [3:0]  mach;
    logic [15:0] ptime;
    logic        first_job;
    logic        last_job;
  } shop_beat_t;

  typedef struct {
    logic [31:0] completion;
    logic [39:0] total;
    logic        done;
  } shop_result_t;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [MCNT_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = FUNC_LOAD;
  logic [JOB_W-1:0]     in_job_id = '0;
  logic [MACH_W-1:0]    in_machine_id = '0;
  logic [15:0]          in_proc_time = '0;
  logic                 in_first_job = 1'b0;
  logic                 in_final_job = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COMP_W-1:0]    out_completion_time;
  logic [TOTAL_W-1:0]   out_flow_time_total;
  logic                 out_sequence_done;

  // Predicted state of the shop.
  logic [15:0]          proc_table [0:1023];
  bit                   table_loaded [0:1023];
  logic [31:0]          prev_job_done [0:15];
  logic [31:0]          prev_mach_done = '0;
  logic [39:0]          flow_sum = '0;
  logic [4:0]           machine_count = 5'd16;

  shop_result_t         pending_results[$];
  int                   mismatch_count = 0;
  int                   beats_sent = 0;
  int                   burst_left = 0;
  bit                   sender_gaps_on = 1'b1;
  bit                   hold_request = 1'b0;
  int                   hold_left = 0;
  rx_mode_t             rx_mode = RX_FREE;
  int                   rx_mode_left = 0;
  logic [2:0]           rx_tick = '0;

  flow_shop_flow_time_eval dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_job_id           (in_job_id),
    .in_machine_id       (in_machine_id),
    .in_proc_time        (in_proc_time),
    .in_first_job        (in_first_job),
    .in_final_job        (in_final_job),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_completion_time (out_completion_time),
    .out_flow_time_total (out_flow_time_total),
    .out_sequence_done   (out_sequence_done)
  );

  always #5 clk = ~clk;

  initial begin
    for (int m = 0; m < 16; m++) prev_job_done[m] = '0;
  end

  function automatic int active_machines();
    if (machine_count == 0) return 1;
    if (machine_count > MAX_MACHINES) return MAX_MACHINES;
    return int'(machine_count);
  endfunction

  // Applies one beat to the predicted shop state and returns its result.
  function automatic shop_result_t advance_schedule(shop_beat_t b);
    shop_result_t r;
    logic [9:0]   idx;
    logic [31:0]  start_at;
    logic [31:0]  from_job;
    logic [32:0]  sum_c;
    logic [31:0]  c;
    logic [40:0]  sum_t;
    bit           last_op;
    idx = {b.job, b.mach};
    if (b.func == FUNC_LOAD) begin
      proc_table[idx] = b.ptime;
      table_loaded[idx] = 1'b1;
      r.completion = '0;
      r.total = flow_sum;
      r.done = 1'b0;
      return r;
    end
    start_at = (b.mach == 0) ? 32'd0 : prev_mach_done;
    from_job = b.first_job ? 32'd0 : prev_job_done[b.mach];
    if (from_job > start_at) start_at = from_job;
    sum_c = {1'b0, start_at} + 33'(proc_table[idx]);
    c = sum_c[32] ? 32'hFFFF_FFFF : sum_c[31:0];
    prev_job_done[b.mach] = c;
    prev_mach_done = c;
    if (b.first_job) flow_sum = '0;
    last_op = (int'(b.mach) == active_machines() - 1);
    if (last_op) begin
      sum_t = {1'b0, flow_sum} + 41'(c);
      flow_sum = sum_t[40] ? 40'hFF_FFFF_FFFF : sum_t[39:0];
    end
    r.completion = c;
    r.total = flow_sum;
    r.done = last_op && b.last_job;
    return r;
  endfunction

  function automatic shop_beat_t make_beat(logic func, logic [5:0] job, logic [3:0] mach,
                                           logic [15:0] ptime, logic first_job,
                                           logic last_job);
    shop_beat_t b;
    b.func = func;
    b.job = job;
    b.mach = mach;
    b.ptime = ptime;
    b.first_job = first_job;
    b.last_job = last_job;
    return b;
  endfunction

  function automatic logic [15:0] pick_duration();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    if (roll < 5) return 16'($urandom_range(0, 40));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // Offers one beat, holding the payload until it is taken. Idle gaps are
  // inserted between bursts when the sender is allowed to idle.
  task automatic send_beat(input shop_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_func       <= b.func;
    in_job_id     <= b.job;
    in_machine_id <= b.mach;
    in_proc_time  <= b.ptime;
    in_first_job  <= b.first_job;
    in_final_job  <= b.last_job;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), advance_schedule(b));
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_machine_count(logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    machine_count = value;
  endtask

  task automatic ensure_loaded(logic [5:0] job, logic [3:0] mach);
    if (!table_loaded[{job, mach}])
      send_beat(make_beat(FUNC_LOAD, job, mach, pick_duration(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
  endtask

  // One well-formed job sequence with random jobs, stray loads mixed in.
  task automatic play_sequence(int n_jobs, bit pause_midway);
    int         span;
    logic [5:0] job;
    span = active_machines();
    for (int k = 0; k < n_jobs; k++) begin
      job = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
      for (int m = 0; m < span; m++) begin
        if ($urandom_range(0, 19) == 0)
          send_beat(make_beat(FUNC_LOAD, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                              pick_duration(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
        ensure_loaded(job, 4'(m));
        send_beat(make_beat(FUNC_EVAL, job, 4'(m), 16'($urandom_range(0, 65535)),
                            k == 0, k == n_jobs - 1));
      end
      if (pause_midway && k == n_jobs / 2) wait_idle();
    end
  endtask

  task automatic noise_beat();
    logic [5:0] job;
    logic [3:0] mach;
    job = 6'($urandom_range(0, 63));
    mach = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 1) == 0) begin
      send_beat(make_beat(FUNC_LOAD, job, mach, pick_duration(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end else begin
      ensure_loaded(job, mach);
      send_beat(make_beat(FUNC_EVAL, job, mach, 16'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_random_traffic(int n_beats);
    int start_count;
    start_count = beats_sent;
    while (beats_sent - start_count < n_beats) begin
      if ($urandom_range(0, 99) < 85) play_sequence($urandom_range(1, 5), 1'b0);
      else noise_beat();
    end
  endtask

  task automatic test_directed_cases();
    write_machine_count(5'd2);
    send_beat(make_beat(FUNC_LOAD, 6'd0,  4'd0,  16'h0000, 1'b1, 1'b1));
    send_beat(make_beat(FUNC_LOAD, 6'd0,  4'd1,  16'hFFFF, 1'b0, 1'b0));
    send_beat(make_beat(FUNC_LOAD, 6'd63, 4'd0,  16'hFFFF, 1'b0, 1'b0));
    send_beat(make_beat(FUNC_LOAD, 6'd63, 4'd1,  16'h0001, 1'b0, 1'b0));
    send_beat(make_beat(FUNC_LOAD, 6'd63, 4'd15, 16'hA5A5, 1'b0, 1'b0));
    send_beat(make_beat(FUNC_LOAD, 6'd42, 4'd0,  16'h5A5A, 1'b0, 1'b0));
    send_beat(make_beat(FUNC_LOAD, 6'd42, 4'd1,  16'h0007, 1'b0, 1'b0));
    // Three-job sequence; the middle job has a zero time on machine 0.
    send_beat(make_beat(FUNC_EVAL, 6'd63, 4'd0, 16'hFFFF, 1'b1, 1'b0));
    send_beat(make_beat(FUNC_EVAL, 6'd63, 4'd1, 16'h0000, 1'b1, 1'b0));
    send_beat(make_beat(FUNC_EVAL, 6'd0,  4'd0, 16'h0000, 1'b0, 1'b0));
    send_beat(make_beat(FUNC_EVAL, 6'd0,  4'd1, 16'h0000, 1'b0, 1'b0));
    send_beat(make_beat(FUNC_EVAL, 6'd42, 4'd0, 16'h0000, 1'b0, 1'b1));
    send_beat(make_beat(FUNC_EVAL, 6'd42, 4'd1, 16'h0000, 1'b0, 1'b1));
    // A load reports the running total unchanged.
    send_beat(make_beat(FUNC_LOAD, 6'd21, 4'd5, 16'h0003, 1'b1, 1'b0));
    // Machine beyond the configured count: computed but not summed.
    send_beat(make_beat(FUNC_EVAL, 6'd63, 4'd15, 16'h0000, 1'b0, 1'b1));
    // A single-job sequence is both first and final.
    send_beat(make_beat(FUNC_EVAL, 6'd42, 4'd0, 16'h0000, 1'b1, 1'b1));
    send_beat(make_beat(FUNC_EVAL, 6'd42, 4'd1, 16'h0000, 1'b1, 1'b1));
    wait_idle();
  endtask

  task automatic test_machine_count_sweep();
    logic [4:0] counts [7];
    counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'($urandom_range(2, 15)),
               5'($urandom_range(0, 31))};
    foreach (counts[i]) begin
      write_machine_count(counts[i]);
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      run_random_traffic(50);
      wait_idle();
    end
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_output_holdoff();
    write_machine_count(5'd4);
    sender_gaps_on = 1'b0;
    hold_request = 1'b1;
    run_random_traffic(60);
    sender_gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_pause_mid_sequence();
    write_machine_count(5'd3);
    play_sequence(4, 1'b1);
    // The machine count may only change once nothing is in flight.
    wait_idle();
    write_machine_count(5'd16);
    play_sequence(2, 1'b1);
    wait_idle();
  endtask

  // Receiver: a random stall pattern that changes now and then, plus a long
  // hold-off on request.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 3'd1;
    if (hold_request) begin
      hold_left = 300;
      hold_request = 1'b0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 120);
    end else begin
      rx_mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:  out_stall <= (rx_tick >= 3'd5);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    shop_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", 40'(out_completion_time), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_completion_time !== want.completion)
          report_mismatch("completion_time", 40'(out_completion_time), 40'(want.completion));
        if (out_flow_time_total !== want.total)
          report_mismatch("flow_time_total", out_flow_time_total, want.total);
        if (out_sequence_done !== want.done)
          report_mismatch("sequence_done", 40'(out_sequence_done), 40'(want.done));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_machine_count_sweep();
    test_output_holdoff();
    test_pause_mid_sequence();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
